// File: design/lcs_with_traceback_unit_macros.svh
// Assertion macros used by the lcs datapath.
// No dependencies; included by files that carry assertions.
`ifndef LCS_WITH_TRACEBACK_UNIT_MACROS_SVH
`define LCS_WITH_TRACEBACK_UNIT_MACROS_SVH

// same-cycle implication
`define LCS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LCS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/lcs_pkg.sv
// Shared types and constants for the LCS with traceback unit.
// No dependencies.
package lcs_pkg;

  localparam int MAX_LEN_DEF = 32;
  localparam int DATA_W      = 32;
  localparam int CMD_W       = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND_A = 2'd0,
    CMD_APPEND_B = 2'd1,
    CMD_COMPUTE  = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL_RD,
    S_FILL_WR,
    S_TB_RD1,
    S_TB_RD2,
    S_TB_DEC,
    S_LEN,
    S_EM_RD,
    S_EM_LD,
    S_CLR
  } state_e;

  typedef struct packed {
    logic load;
    logic start;
    logic fill_rd;
    logic fill_wr;
    logic tb_rd1;
    logic tb_rd2;
    logic tb_dec;
    logic len_ld;
    logic em_rd;
    logic em_ld;
    logic clear;
  } ctrl_t;

  typedef struct packed {
    logic out_free;
    logic empty;
    logic last_col;
    logic last_row;
    logic tb_stop;
    logic k_zero;
    logic em_last;
  } stat_t;

endpackage

// File: design/lcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lcs_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// File: design/lcs_dp.sv
// Datapath: sequence stores, table memory, counters, traceback and output register.
// Depends on lcs_pkg, lcs_ram and the macros header.
`include "lcs_with_traceback_unit_macros.svh"
module lcs_dp #(
  parameter int MaxLen = lcs_pkg::MAX_LEN_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lcs_pkg::ctrl_t               ctrl_i,
  output lcs_pkg::stat_t               stat_o,
  input  logic [lcs_pkg::CMD_W-1:0]    cmd_i,
  input  logic [lcs_pkg::DATA_W-1:0]   elem_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [lcs_pkg::DATA_W-1:0]   out_value_o,
  output logic                         out_is_length_o,
  output logic                         out_last_o,
  output logic                         out_overflow_o
);
  localparam int CW  = $clog2(MaxLen + 1);
  localparam int AW  = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int TD  = MaxLen * MaxLen;
  localparam int DAW = (TD > 1) ? $clog2(TD) : 1;
  localparam int BW  = $clog2(TD + 1) + 1;
  localparam int DW  = lcs_pkg::DATA_W;

  logic [CW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic          drop_q, drop_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, k_q, k_d, r_q, r_d;
  logic [BW-1:0] base_q, base_d;
  logic [CW-1:0] left_q, left_d, diag_q, diag_d, up_q, up_d;
  logic          eq_q, eq_d;

  logic          out_valid_q, out_valid_d;
  logic [DW-1:0] out_value_q, out_value_d;
  logic          out_isl_q, out_isl_d, out_last_q, out_last_d, out_ov_q, out_ov_d;

  // ram ports
  logic          a_we, b_we, a_re, t_we, t_re, d_we, d_re;
  logic [AW-1:0] a_waddr, b_waddr, ab_raddr_a, ab_raddr_b, t_waddr, t_raddr;
  logic [DW-1:0] a_rd, b_rd, t_rd;
  logic [DAW-1:0] d_waddr, d_raddr;
  logic [CW-1:0] d_wdata, d_rd;

  logic [CW-1:0] i_m1, j_m1, cell_v, up_v, left_v, em_idx;
  logic [BW-1:0] base_prev, up_addr, left_addr, wr_addr;
  logic          load_a, load_b, eq_now, take_up;

  assign i_m1      = i_q - 1'b1;
  assign j_m1      = j_q - 1'b1;
  assign base_prev = base_q - BW'(MaxLen);
  assign up_addr   = base_prev + BW'(j_q) - 1'b1;
  assign left_addr = base_q + BW'(j_q) - BW'(2);
  assign wr_addr   = base_q + BW'(j_q) - 1'b1;
  assign eq_now    = (a_rd == b_rd);
  assign up_v      = (i_q == CW'(1)) ? '0 : d_rd;
  assign left_v    = (j_q == CW'(1)) ? '0 : d_rd;
  assign cell_v    = eq_now ? (diag_q + 1'b1) : ((up_v >= left_q) ? up_v : left_q);
  assign take_up   = (up_q >= left_v);
  assign em_idx    = k_q - r_q - 1'b1;

  assign load_a = ctrl_i.load && (lcs_pkg::cmd_e'(cmd_i) == lcs_pkg::CMD_APPEND_A);
  assign load_b = ctrl_i.load && (lcs_pkg::cmd_e'(cmd_i) == lcs_pkg::CMD_APPEND_B);

  assign a_we    = load_a && (cnt_a_q != CW'(MaxLen));
  assign b_we    = load_b && (cnt_b_q != CW'(MaxLen));
  assign a_waddr = cnt_a_q[AW-1:0];
  assign b_waddr = cnt_b_q[AW-1:0];
  assign a_re    = ctrl_i.fill_rd || ctrl_i.tb_rd1;
  assign ab_raddr_a = i_m1[AW-1:0];
  assign ab_raddr_b = j_m1[AW-1:0];
  assign d_re    = ctrl_i.fill_rd || ctrl_i.tb_rd1 || ctrl_i.tb_rd2;
  assign d_raddr = ctrl_i.tb_rd2 ? left_addr[DAW-1:0] : up_addr[DAW-1:0];
  assign d_we    = ctrl_i.fill_wr;
  assign d_waddr = wr_addr[DAW-1:0];
  assign d_wdata = cell_v;
  assign t_we    = ctrl_i.tb_dec && eq_q;
  assign t_waddr = k_q[AW-1:0];
  assign t_re    = ctrl_i.em_rd;
  assign t_raddr = em_idx[AW-1:0];

  lcs_ram #(.Width(DW), .Depth(MaxLen)) u_seq_a (
    .clk_i, .we_i(a_we), .waddr_i(a_waddr), .wdata_i(elem_i),
    .re_i(a_re), .raddr_i(ab_raddr_a), .rdata_o(a_rd)
  );
  lcs_ram #(.Width(DW), .Depth(MaxLen)) u_seq_b (
    .clk_i, .we_i(b_we), .waddr_i(b_waddr), .wdata_i(elem_i),
    .re_i(a_re), .raddr_i(ab_raddr_b), .rdata_o(b_rd)
  );
  lcs_ram #(.Width(CW), .Depth(TD)) u_table (
    .clk_i, .we_i(d_we), .waddr_i(d_waddr), .wdata_i(d_wdata),
    .re_i(d_re), .raddr_i(d_raddr), .rdata_o(d_rd)
  );
  lcs_ram #(.Width(DW), .Depth(MaxLen)) u_trace (
    .clk_i, .we_i(t_we), .waddr_i(t_waddr), .wdata_i(a_rd),
    .re_i(t_re), .raddr_i(t_raddr), .rdata_o(t_rd)
  );

  always_comb begin
    cnt_a_d = cnt_a_q;
    cnt_b_d = cnt_b_q;
    drop_d  = drop_q;
    i_d = i_q; j_d = j_q; k_d = k_q; r_d = r_q;
    base_d = base_q; left_d = left_q; diag_d = diag_q; up_d = up_q; eq_d = eq_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_value_d = out_value_q;
    out_isl_d = out_isl_q; out_last_d = out_last_q; out_ov_d = out_ov_q;

    if (a_we) cnt_a_d = cnt_a_q + 1'b1;
    if (b_we) cnt_b_d = cnt_b_q + 1'b1;
    if ((load_a && !a_we) || (load_b && !b_we)) drop_d = 1'b1;

    if (ctrl_i.start) begin
      i_d = CW'(1); j_d = CW'(1); k_d = '0; r_d = '0;
      base_d = '0; left_d = '0; diag_d = '0;
    end

    if (ctrl_i.fill_wr) begin
      left_d = cell_v;
      diag_d = up_v;
      if (j_q == cnt_b_q) begin
        if (i_q != cnt_a_q) begin
          i_d = i_q + 1'b1;
          j_d = CW'(1);
          base_d = base_q + BW'(MaxLen);
          left_d = '0;
          diag_d = '0;
        end
      end else begin
        j_d = j_q + 1'b1;
      end
    end

    if (ctrl_i.tb_rd2) begin
      eq_d = eq_now;
      up_d = up_v;
    end

    if (ctrl_i.tb_dec) begin
      if (eq_q) begin
        k_d = k_q + 1'b1;
        i_d = i_m1;
        j_d = j_m1;
        base_d = base_prev;
      end else if (take_up) begin
        i_d = i_m1;
        base_d = base_prev;
      end else begin
        j_d = j_m1;
      end
    end

    if (ctrl_i.len_ld) begin
      out_valid_d = 1'b1;
      out_value_d = DW'(k_q);
      out_isl_d   = 1'b1;
      out_last_d  = (k_q == '0);
      out_ov_d    = drop_q;
    end

    if (ctrl_i.em_ld) begin
      out_valid_d = 1'b1;
      out_value_d = t_rd;
      out_isl_d   = 1'b0;
      out_last_d  = (r_q + 1'b1 == k_q);
      out_ov_d    = drop_q;
      r_d         = r_q + 1'b1;
    end

    if (ctrl_i.clear) begin
      cnt_a_d = '0;
      cnt_b_d = '0;
      drop_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; k_q <= k_d; r_q <= r_d;
    base_q <= base_d; left_q <= left_d; diag_q <= diag_d; up_q <= up_d; eq_q <= eq_d;
    out_value_q <= out_value_d;
    out_isl_q <= out_isl_d; out_last_q <= out_last_d; out_ov_q <= out_ov_d;
  end

  always_comb begin
    stat_o.out_free = !out_valid_q || out_ready_i;
    stat_o.empty    = (cnt_a_q == '0) || (cnt_b_q == '0);
    stat_o.last_col = (j_q == cnt_b_q);
    stat_o.last_row = (i_q == cnt_a_q);
    stat_o.tb_stop  = eq_q ? ((i_q == CW'(1)) || (j_q == CW'(1)))
                           : (take_up ? (i_q == CW'(1)) : (j_q == CW'(1)));
    stat_o.k_zero   = (k_q == '0);
    stat_o.em_last  = (r_q + 1'b1 == k_q);
  end

  assign out_valid_o     = out_valid_q;
  assign out_value_o     = out_value_q;
  assign out_is_length_o = out_isl_q;
  assign out_last_o      = out_last_q;
  assign out_overflow_o  = out_ov_q;

  `LCS_ASSERT_IMP(a_cnt_a_cap, clk_i, rst_ni, 1'b1, cnt_a_q <= CW'(MaxLen), "first count past capacity")
  `LCS_ASSERT_IMP(a_trace_cap, clk_i, rst_ni, t_we, k_q < CW'(MaxLen), "trace write past capacity")
  `LCS_ASSERT_NXT(a_drop_set, clk_i, rst_ni, load_a && !a_we && !ctrl_i.clear, drop_q, "overflow not flagged")
endmodule

// File: design/lcs_ctrl.sv
// Controller state machine sequencing load, table fill, traceback and emit.
// Depends on lcs_pkg.
module lcs_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [lcs_pkg::CMD_W-1:0] in_cmd_i,
  output logic                      in_ready_o,
  input  lcs_pkg::stat_t            stat_i,
  output lcs_pkg::ctrl_t            ctrl_o
);
  lcs_pkg::state_e state_q, state_d;
  logic            go;

  assign go = in_valid_i && (state_q == lcs_pkg::S_IDLE)
              && (lcs_pkg::cmd_e'(in_cmd_i) == lcs_pkg::CMD_COMPUTE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lcs_pkg::S_IDLE:    if (go) state_d = stat_i.empty ? lcs_pkg::S_LEN : lcs_pkg::S_FILL_RD;
      lcs_pkg::S_FILL_RD: state_d = lcs_pkg::S_FILL_WR;
      lcs_pkg::S_FILL_WR: begin
        if (stat_i.last_col && stat_i.last_row) state_d = lcs_pkg::S_TB_RD1;
        else state_d = lcs_pkg::S_FILL_RD;
      end
      lcs_pkg::S_TB_RD1:  state_d = lcs_pkg::S_TB_RD2;
      lcs_pkg::S_TB_RD2:  state_d = lcs_pkg::S_TB_DEC;
      lcs_pkg::S_TB_DEC:  state_d = stat_i.tb_stop ? lcs_pkg::S_LEN : lcs_pkg::S_TB_RD1;
      lcs_pkg::S_LEN: begin
        if (stat_i.out_free) state_d = stat_i.k_zero ? lcs_pkg::S_CLR : lcs_pkg::S_EM_RD;
      end
      lcs_pkg::S_EM_RD:   state_d = lcs_pkg::S_EM_LD;
      lcs_pkg::S_EM_LD: begin
        if (stat_i.out_free) state_d = stat_i.em_last ? lcs_pkg::S_CLR : lcs_pkg::S_EM_RD;
      end
      lcs_pkg::S_CLR:     state_d = lcs_pkg::S_IDLE;
      default:            state_d = lcs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lcs_pkg::S_IDLE: begin
        in_ready_o   = 1'b1;
        ctrl_o.load  = in_valid_i;
        ctrl_o.start = go;
      end
      lcs_pkg::S_FILL_RD: ctrl_o.fill_rd = 1'b1;
      lcs_pkg::S_FILL_WR: ctrl_o.fill_wr = 1'b1;
      lcs_pkg::S_TB_RD1:  ctrl_o.tb_rd1  = 1'b1;
      lcs_pkg::S_TB_RD2:  ctrl_o.tb_rd2  = 1'b1;
      lcs_pkg::S_TB_DEC:  ctrl_o.tb_dec  = 1'b1;
      lcs_pkg::S_LEN:     ctrl_o.len_ld  = stat_i.out_free;
      lcs_pkg::S_EM_RD:   ctrl_o.em_rd   = 1'b1;
      lcs_pkg::S_EM_LD:   ctrl_o.em_ld   = stat_i.out_free;
      lcs_pkg::S_CLR:     ctrl_o.clear   = 1'b1;
      default:            ctrl_o         = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

// File: design/lcs_with_traceback_unit.sv
// Load items (cmd 0/1) are taken while the unit is idle. A compute item runs the
// table fill (one table RAM port, read-then-write per cell in FILL_RD and FILL_WR),
// then traceback steps (at most n+m steps, each TB_RD1, TB_RD2, TB_DEC), then EM_RD
// and EM_LD per result; the length result and each element wait for a free output.
// Reset (async, active low) clears the counts, overflow flag, state and output valid;
// the memories are not cleared; table reads of unfilled cells are masked to zero.
module lcs_with_traceback_unit #(
  parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [31:0] element
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [31:0] value
  output logic [1:0]  m_axis_tuser_o,  // [0] is_length, [1] overflow
  output logic        m_axis_tlast_o   // last
);
  lcs_pkg::ctrl_t ctrl;
  lcs_pkg::stat_t stat;
  logic           ready;

  lcs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_cmd_i(s_axis_tuser_i), .in_ready_o(ready),
    .stat_i(stat), .ctrl_o(ctrl)
  );

  lcs_dp #(.MaxLen(MAX_LEN)) u_dp (
    .clk_i, .rst_ni,
    .ctrl_i(ctrl), .stat_o(stat),
    .cmd_i(s_axis_tuser_i), .elem_i(s_axis_tdata_i),
    .out_ready_i(m_axis_tready_i), .out_valid_o(m_axis_tvalid_o),
    .out_value_o(m_axis_tdata_o), .out_is_length_o(m_axis_tuser_o[0]),
    .out_last_o(m_axis_tlast_o), .out_overflow_o(m_axis_tuser_o[1])
  );

  assign s_axis_tready_o = ready;
endmodule
